[src/csib_pkg.sv]
// ----------------------------------------------------------------------------
// csib_pkg
// Shared types, codes and constants of the challenge sampler.
// ----------------------------------------------------------------------------
package csib_pkg;

  // prime modulus of the coefficient ring
  localparam logic [22:0] MODQ          = 23'd8380417;
  localparam int unsigned SIGN_BYTES    = 8;
  localparam logic [6:0]  MAX_WEIGHT    = 7'd64;
  localparam logic [6:0]  WEIGHT_RESET  = 7'd39;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  // stored coefficient codes
  typedef enum logic [1:0] {
    CODE_ZERO  = 2'd0,
    CODE_PLUS  = 2'd1,
    CODE_MINUS = 2'd2
  } code_e;

  // request from the front end to the store, one per transaction
  typedef struct packed {
    func_e       func;
    logic        place;
    logic [7:0]  hash_byte;
    logic [7:0]  pos;
    logic        neg;
    logic        rd_ok;
    logic [7:0]  read_index;
  } req_t;

  // status fields of one result
  typedef struct packed {
    logic        byte_accepted;
    logic        ball_done;
    logic [6:0]  placed_so_far;
  } stat_t;

  // code to value mod q
  function automatic logic [22:0] code_value(input code_e code);
    logic [22:0] v;
    case (code)
      CODE_PLUS:  v = 23'd1;
      CODE_MINUS: v = MODQ - 23'd1;
      default:    v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

[src/csib_if.sv]
// ----------------------------------------------------------------------------
// csib_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface csib_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] hash_byte;
  logic [7:0] read_index;

  modport source (output valid, output func, output hash_byte, output read_index,
                  input ready);
  modport sink   (input valid, input func, input hash_byte, input read_index,
                  output ready);
endinterface

interface csib_out_if;
  logic        valid;
  logic        ready;
  logic [22:0] coeff_value;
  logic        byte_accepted;
  logic        ball_done;
  logic [6:0]  placed_so_far;

  modport source (output valid, output coeff_value, output byte_accepted,
                  output ball_done, output placed_so_far, input ready);
  modport sink   (input valid, input coeff_value, input byte_accepted,
                  input ball_done, input placed_so_far, output ready);
endinterface

[src/csib_ram.sv]
// ----------------------------------------------------------------------------
// csib_ram
// Generic RAM with two write ports and one registered read port.
// ----------------------------------------------------------------------------
module csib_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we0_i,
  input  logic [$clog2(DEPTH)-1:0] waddr0_i,
  input  logic [WIDTH-1:0]         wdata0_i,
  input  logic                     we1_i,
  input  logic [$clog2(DEPTH)-1:0] waddr1_i,
  input  logic [WIDTH-1:0]         wdata1_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write ports, port 1 wins when both hit the same entry
  always_ff @(posedge clk_i) begin
    if (we0_i) begin
      mem_q[waddr0_i] <= wdata0_i;
    end
    if (we1_i) begin
      mem_q[waddr1_i] <= wdata1_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/csib_ctrl.sv]
// ----------------------------------------------------------------------------
// csib_ctrl
// Front end: weight register, sign word, counters and placement decision.
// ----------------------------------------------------------------------------
module csib_ctrl #(
  parameter int unsigned N_COEFFS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [1:0]      func_i,
  input  logic [7:0]      hash_byte_i,
  input  logic [7:0]      read_index_i,
  input  logic            cfg_we_i,
  input  logic [6:0]      cfg_wdata_i,
  output csib_pkg::req_t  req_o,
  output csib_pkg::stat_t stat_o
);

  logic [6:0]  weight_q;
  logic [63:0] sign_q, sign_d;
  logic [3:0]  sign_cnt_q, sign_cnt_d;
  logic [6:0]  placed_q, placed_d;
  logic [6:0]  tau;
  logic [8:0]  pos;
  logic        place;
  csib_pkg::func_e func;

  assign func = csib_pkg::func_e'(func_i);

  // weight saturates at the largest supported value
  assign tau = (weight_q > csib_pkg::MAX_WEIGHT) ? csib_pkg::MAX_WEIGHT : weight_q;

  // target position for the next placement
  assign pos = 9'(N_COEFFS) - {2'b00, tau} + {2'b00, placed_q};

  assign place = (func == csib_pkg::FUNC_BYTE) && sign_cnt_q[3] && (placed_q < tau)
              && ({1'b0, hash_byte_i} <= pos) && (pos < 9'(N_COEFFS));

  // next state of sign word and counters
  always_comb begin
    sign_d     = sign_q;
    sign_cnt_d = sign_cnt_q;
    placed_d   = placed_q;
    case (func)
      csib_pkg::FUNC_START: begin
        sign_d     = '0;
        sign_cnt_d = '0;
        placed_d   = '0;
      end
      csib_pkg::FUNC_BYTE: begin
        if (!sign_cnt_q[3]) begin
          sign_d[{sign_cnt_q[2:0], 3'b000} +: 8] =
            sign_q[{sign_cnt_q[2:0], 3'b000} +: 8] | hash_byte_i;
          sign_cnt_d = sign_cnt_q + 4'd1;
        end else if (place) begin
          placed_d = placed_q + 7'd1;
        end
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q   <= csib_pkg::WEIGHT_RESET;
      sign_q     <= '0;
      sign_cnt_q <= '0;
      placed_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        weight_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        sign_q     <= sign_d;
        sign_cnt_q <= sign_cnt_d;
        placed_q   <= placed_d;
      end
    end
  end

  // request to the store
  always_comb begin
    req_o.func       = func;
    req_o.place      = place;
    req_o.hash_byte  = hash_byte_i;
    req_o.pos        = pos[7:0];
    req_o.neg        = sign_q[placed_q[5:0]];
    req_o.rd_ok      = ({1'b0, read_index_i} < 9'(N_COEFFS));
    req_o.read_index = read_index_i;
  end

  // status of this transaction
  always_comb begin
    stat_o.byte_accepted = place;
    stat_o.ball_done     = (placed_d >= tau);
    stat_o.placed_so_far = placed_d;
  end

endmodule

[src/csib_store.sv]
// ----------------------------------------------------------------------------
// csib_store
// Coefficient store: one RAM with two write ports, valid bits and forwarding.
// ----------------------------------------------------------------------------
module csib_store #(
  parameter int unsigned N_COEFFS = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rd_en_i,
  input  csib_pkg::req_t req_i,
  input  logic           adv_i,
  output logic [22:0]    coeff_o
);

  localparam int unsigned AW = $clog2(N_COEFFS);

  csib_pkg::req_t      req_q;
  logic [N_COEFFS-1:0] valid_q;
  logic                fwd_valid_q;
  logic [AW-1:0]       fwd_b_q, fwd_pos_q;
  csib_pkg::code_e     fwd_b_code_q, fwd_pos_code_q;

  logic [AW-1:0]   raddr, s1_addr, s1_b, s1_pos;
  logic [1:0]      rdata;
  csib_pkg::code_e ram_code, cur_code, new_code;
  logic            we;

  // read address: hash byte for byte transactions, index otherwise
  assign raddr = (req_i.func == csib_pkg::FUNC_BYTE) ? AW'(req_i.hash_byte)
                                                     : AW'(req_i.read_index);

  // second stage request
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      req_q <= req_i;
    end
  end

  assign s1_addr = (req_q.func == csib_pkg::FUNC_BYTE) ? AW'(req_q.hash_byte)
                                                       : AW'(req_q.read_index);
  assign s1_b    = AW'(req_q.hash_byte);
  assign s1_pos  = AW'(req_q.pos);
  assign we      = adv_i && (req_q.func == csib_pkg::FUNC_BYTE) && req_q.place;
  assign new_code = req_q.neg ? csib_pkg::CODE_MINUS : csib_pkg::CODE_PLUS;

  // displaced coefficient goes to pos, the new sign to b and wins on a tie
  csib_ram #(.WIDTH(2), .DEPTH(N_COEFFS)) u_ram (
    .clk_i    (clk_i),
    .we0_i    (we),
    .waddr0_i (s1_pos),
    .wdata0_i (cur_code),
    .we1_i    (we),
    .waddr1_i (s1_b),
    .wdata1_i (new_code),
    .re_i     (rd_en_i),
    .raddr_i  (raddr),
    .rdata_o  (rdata)
  );

  // entries not written since the last start read as zero
  assign ram_code = valid_q[s1_addr] ? csib_pkg::code_e'(rdata) : csib_pkg::CODE_ZERO;

  // forward the write that landed in the same cycle as this read
  always_comb begin
    if (fwd_valid_q && (fwd_b_q == s1_addr)) begin
      cur_code = fwd_b_code_q;
    end else if (fwd_valid_q && (fwd_pos_q == s1_addr)) begin
      cur_code = fwd_pos_code_q;
    end else begin
      cur_code = ram_code;
    end
  end

  // read result
  assign coeff_o = ((req_q.func == csib_pkg::FUNC_READ) && req_q.rd_ok)
                 ? csib_pkg::code_value(cur_code) : 23'd0;

  // valid bits and forwarding record, cleared by a start transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      fwd_valid_q <= 1'b0;
    end else if (adv_i && (req_q.func == csib_pkg::FUNC_START)) begin
      valid_q     <= '0;
      fwd_valid_q <= 1'b0;
    end else if (we) begin
      valid_q[s1_pos] <= 1'b1;
      valid_q[s1_b]   <= 1'b1;
      fwd_valid_q     <= 1'b1;
    end
  end

  // forwarding payload
  always_ff @(posedge clk_i) begin
    if (we) begin
      fwd_b_q        <= s1_b;
      fwd_b_code_q   <= new_code;
      fwd_pos_q      <= s1_pos;
      fwd_pos_code_q <= cur_code;
    end
  end

endmodule

[src/challenge_sample_in_ball_top.sv]
// ----------------------------------------------------------------------------
// challenge_sample_in_ball_top
// Challenge sampler: builds a sparse +1/-1 challenge from a hash byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one transaction per item: func selects start, hash byte or
//   read. A start clears the challenge; the first eight hash bytes after it
//   fill the sign word, later bytes place coefficients until the weight is
//   reached. A read returns the coefficient as 0, 1 or q-1.
//   out_o returns exactly one result per input transaction, in order.
//   Each result passes the registered memory read, then the output register.
//   Throughput is one transaction per cycle unless out_o stalls; the store's
//   read-modify-write is pipelined and a same-cycle write is forwarded.
//   cfg_we_i / cfg_wdata_i write the weight register (tau); the user must
//   write it only while idle, as the block does not enforce this.
//   Reset clears the challenge and loads weight 39; per-entry valid bits are
//   cleared at once, so no clearing pass is needed.
//   When out_o.ready is low the output register holds; one more transaction
//   can sit in the read stage, after which in_i.ready drops.
// ----------------------------------------------------------------------------
module challenge_sample_in_ball_top #(
  parameter int unsigned N_COEFFS = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [6:0]     cfg_wdata_i,
  csib_in_if.sink        in_i,
  csib_out_if.source     out_o
);

  logic            accept;
  logic            adv;
  logic            s1_valid_q;
  logic            out_valid_q;
  csib_pkg::req_t  req;
  csib_pkg::stat_t stat, s1_stat_q, out_stat_q;
  logic [22:0]     coeff, out_coeff_q;

  // handshake
  assign adv        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  csib_ctrl #(.N_COEFFS(N_COEFFS)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .func_i       (in_i.func),
    .hash_byte_i  (in_i.hash_byte),
    .read_index_i (in_i.read_index),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_o        (req),
    .stat_o       (stat)
  );

  csib_store #(.N_COEFFS(N_COEFFS)) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (accept),
    .req_i   (req),
    .adv_i   (adv),
    .coeff_o (coeff)
  );

  // pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // status and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_stat_q <= stat;
    end
    if (adv) begin
      out_stat_q  <= s1_stat_q;
      out_coeff_q <= coeff;
    end
  end

  // result channel
  assign out_o.valid         = out_valid_q;
  assign out_o.coeff_value   = out_coeff_q;
  assign out_o.byte_accepted = out_stat_q.byte_accepted;
  assign out_o.ball_done     = out_stat_q.ball_done;
  assign out_o.placed_so_far = out_stat_q.placed_so_far;

endmodule
